[rtl/ofb_pkg.sv]
// Package for the octree face binning block: shared constants and types.
// Used by ofb_lane, octree_face_binning and the testbench.
package ofb_pkg;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_X_MIN = 3'd0,
    REG_X_MAX = 3'd1,
    REG_Y_MIN = 3'd2,
    REG_Y_MAX = 3'd3,
    REG_Z_MIN = 3'd4,
    REG_Z_MAX = 3'd5
  } cfg_reg_t;

  // Input item kinds.
  localparam logic KIND_BIN  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  localparam int COORD_W = 32;
  localparam logic [COORD_W-1:0] SIGN_BIAS = 32'h8000_0000;

  // Box bounds in offset binary, one per axis.
  typedef struct packed {
    logic [COORD_W-1:0] lo;
    logic [COORD_W-1:0] hi;
  } span_t;

  typedef struct packed {
    span_t x;
    span_t y;
    span_t z;
  } box_t;

  // Vertex coordinates in offset binary.
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
  } vert_t;

  typedef struct packed {
    vert_t a;
    vert_t b;
    vert_t c;
  } tri_t;

  // True when all three vertices lie inside the box, bounds inclusive.
  function automatic logic tri_in_box(input tri_t t, input box_t b);
    logic ok;
    ok = 1'b1;
    ok &= (t.a.x >= b.x.lo) && (t.a.x <= b.x.hi);
    ok &= (t.a.y >= b.y.lo) && (t.a.y <= b.y.hi);
    ok &= (t.a.z >= b.z.lo) && (t.a.z <= b.z.hi);
    ok &= (t.b.x >= b.x.lo) && (t.b.x <= b.x.hi);
    ok &= (t.b.y >= b.y.lo) && (t.b.y <= b.y.hi);
    ok &= (t.b.z >= b.z.lo) && (t.b.z <= b.z.hi);
    ok &= (t.c.x >= b.x.lo) && (t.c.x <= b.x.hi);
    ok &= (t.c.y >= b.y.lo) && (t.c.y <= b.y.hi);
    ok &= (t.c.z >= b.z.lo) && (t.c.z <= b.z.hi);
    return ok;
  endfunction

endpackage

[rtl/ofb_ram.sv]
// Generic single-port RAM with a registered read.
// No dependencies.
module ofb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 37449
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One access per cycle at one address: a write when we is high, and a registered read of the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[rtl/ofb_lane.sv]
// One child-octant lane: builds the child box for its octant and tests the triangle.
// Depends on ofb_pkg.
module ofb_lane
  import ofb_pkg::*;
#(
  parameter logic [2:0] OCTANT = 3'd0
) (
  input  tri_t  tri_i,
  input  box_t  box_i,
  input  vert_t mid_i,
  output box_t  child_o,
  output logic  hit_o
);

  // Octants 0..3 run xlo/ylo, xlo/yhi, xhi/yhi, xhi/ylo; bit 2 picks z.
  localparam logic HX = OCTANT[1];
  localparam logic HY = OCTANT[1] ^ OCTANT[0];
  localparam logic HZ = OCTANT[2];

  always_comb begin
    child_o.x.lo = HX ? mid_i.x : box_i.x.lo;
    child_o.x.hi = HX ? box_i.x.hi : mid_i.x;
    child_o.y.lo = HY ? mid_i.y : box_i.y.lo;
    child_o.y.hi = HY ? box_i.y.hi : mid_i.y;
    child_o.z.lo = HZ ? mid_i.z : box_i.z.lo;
    child_o.z.hi = HZ ? box_i.z.hi : mid_i.z;
    hit_o = tri_in_box(tri_i, child_o);
  end

endmodule

[rtl/octree_face_binning.sv]
// Top level of the octree face binning block: descent sequencer, eight octant
// lanes with a first-hit merge, and the counter store. Depends on ofb_pkg,
// ofb_lane and ofb_ram.
//
// Usage: an input transfer carries either a triangle to bin (kind 0) or a node
// number to read (kind 1). Every input item gives exactly one result transfer.
// A bin item is tested against the root box; if inside, the block descends one
// tree level per cycle, eight lanes testing all children at once and the first
// hit in octant order winning. The deepest node's counter is then read,
// incremented with saturation and written back. A bin item inside the root box
// passes the descend, read, write and output states in turn; a read item or a
// bin item outside the root skips the descent. One item is in flight at a time.
// After reset the counter store is swept to zero, one entry a cycle, over all
// NODE_COUNT entries (37449 at the defaults); no input is accepted meanwhile.
// Configuration writes are taken at any time and apply from the next item.
// A result waits in the output register while out_stall is high; the next
// item is accepted only once that result has been transferred.
module octree_face_binning
  import ofb_pkg::*;
#(
  parameter int TREE_LEVELS = 6,
  parameter int COUNT_BITS  = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [31:0] in_ax,
  input  logic [31:0] in_ay,
  input  logic [31:0] in_az,
  input  logic [31:0] in_bx,
  input  logic [31:0] in_by,
  input  logic [31:0] in_bz,
  input  logic [31:0] in_cx,
  input  logic [31:0] in_cy,
  input  logic [31:0] in_cz,
  input  logic [15:0] in_read_node,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_inside_root,
  output logic [15:0] out_node_number,
  output logic [2:0]  out_node_level,
  output logic [23:0] out_node_total
);

  localparam int NODE_COUNT = ((1 << (3 * TREE_LEVELS)) - 1) / 7;
  localparam int AW         = $clog2(NODE_COUNT);
  localparam int IDX_W      = 3 * TREE_LEVELS;
  localparam int LVL_W      = 3;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_DESCEND, S_RD, S_WR, S_OUT
  } state_t;

  // Level start numbers, (8^L-1)/7.
  function automatic logic [AW-1:0] level_start(input logic [LVL_W-1:0] lv);
    logic [IDX_W:0] s;
    s = '0;
    for (int i = 0; i < 8; i++) begin
      if (i < int'(lv)) s = (s << 3) | 1'b1;
    end
    return s[AW-1:0];
  endfunction

  // Configuration registers in offset binary.
  box_t root_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_r.x.lo <= SIGN_BIAS;
      root_r.x.hi <= 32'h0001_0000 ^ SIGN_BIAS;
      root_r.y.lo <= SIGN_BIAS;
      root_r.y.hi <= 32'h0001_0000 ^ SIGN_BIAS;
      root_r.z.lo <= SIGN_BIAS;
      root_r.z.hi <= 32'h0001_0000 ^ SIGN_BIAS;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_X_MIN: root_r.x.lo <= cfg_data ^ SIGN_BIAS;
        REG_X_MAX: root_r.x.hi <= cfg_data ^ SIGN_BIAS;
        REG_Y_MIN: root_r.y.lo <= cfg_data ^ SIGN_BIAS;
        REG_Y_MAX: root_r.y.hi <= cfg_data ^ SIGN_BIAS;
        REG_Z_MIN: root_r.z.lo <= cfg_data ^ SIGN_BIAS;
        REG_Z_MAX: root_r.z.hi <= cfg_data ^ SIGN_BIAS;
        default: ;
      endcase
    end
  end

  state_t            state_r;
  tri_t              tri_r;
  box_t              box_r;
  logic [IDX_W-1:0]  idx_r;
  logic [LVL_W-1:0]  lvl_r;
  logic [AW-1:0]     addr_r;
  logic              hit_root_r;
  logic              kind_r;
  logic              inrange_r;
  logic [15:0]       rnode_r;
  logic              res_inside_r;
  logic [15:0]       res_node_r;
  logic [2:0]        res_lvl_r;
  logic [23:0]       res_total_r;

  // Midpoints without overflow.
  vert_t mid;
  assign mid.x = COORD_W'(({1'b0, box_r.x.lo} + {1'b0, box_r.x.hi}) >> 1);
  assign mid.y = COORD_W'(({1'b0, box_r.y.lo} + {1'b0, box_r.y.hi}) >> 1);
  assign mid.z = COORD_W'(({1'b0, box_r.z.lo} + {1'b0, box_r.z.hi}) >> 1);

  // Eight lanes, one per child octant.
  box_t       child [8];
  logic [7:0] hit;

  for (genvar g = 0; g < 8; g++) begin : g_lane
    ofb_lane #(.OCTANT(3'(g))) u_lane (
      .tri_i  (tri_r),
      .box_i  (box_r),
      .mid_i  (mid),
      .child_o(child[g]),
      .hit_o  (hit[g])
    );
  end

  // Merge: first hit in octant order wins.
  logic [2:0] pick;
  always_comb begin
    pick = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (hit[i]) pick = 3'(i);
    end
  end

  // Counter store.
  logic                  ram_we;
  logic [AW-1:0]         ram_addr;
  logic [COUNT_BITS-1:0] ram_wdata;
  logic [COUNT_BITS-1:0] ram_rdata;
  logic [COUNT_BITS-1:0] new_cnt;

  ofb_ram #(.WIDTH(COUNT_BITS), .DEPTH(NODE_COUNT)) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  // Saturating increment of the counter just read.
  assign new_cnt = (ram_rdata == COUNT_MAX) ? ram_rdata : ram_rdata + 1'b1;

  always_comb begin
    ram_we    = (state_r == S_CLEAR) || (state_r == S_WR && hit_root_r);
    ram_addr  = addr_r;
    ram_wdata = (state_r == S_CLEAR) ? '0 : new_cnt;
  end

  // Level of a node number for reads.
  logic [LVL_W-1:0] rd_lvl;
  always_comb begin
    rd_lvl = '0;
    for (int l = 1; l < TREE_LEVELS; l++) begin
      if ({{(32-16){1'b0}}, in_read_node} >= 32'(level_start(LVL_W'(l))))
        rd_lvl = LVL_W'(l);
    end
  end

  logic in_acc, out_acc;
  tri_t in_tri;
  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    in_tri.a.x = in_ax ^ SIGN_BIAS;
    in_tri.a.y = in_ay ^ SIGN_BIAS;
    in_tri.a.z = in_az ^ SIGN_BIAS;
    in_tri.b.x = in_bx ^ SIGN_BIAS;
    in_tri.b.y = in_by ^ SIGN_BIAS;
    in_tri.b.z = in_bz ^ SIGN_BIAS;
    in_tri.c.x = in_cx ^ SIGN_BIAS;
    in_tri.c.y = in_cy ^ SIGN_BIAS;
    in_tri.c.z = in_cz ^ SIGN_BIAS;
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      addr_r  <= '0;
    end else begin
      case (state_r)
        S_CLEAR: begin
          if (addr_r == AW'(NODE_COUNT - 1)) begin
            state_r <= S_IDLE;
          end
          addr_r <= addr_r + 1'b1;
        end
        S_IDLE: begin
          if (in_acc) begin
            kind_r  <= in_kind;
            rnode_r <= in_read_node;
            tri_r   <= in_tri;
            box_r   <= root_r;
            idx_r   <= '0;
            if (in_kind == KIND_READ) begin
              hit_root_r <= 1'b0;
              inrange_r  <= (32'(in_read_node) < NODE_COUNT);
              lvl_r      <= rd_lvl;
              addr_r     <= in_read_node[AW-1:0];
              state_r    <= S_RD;
            end else begin
              hit_root_r <= tri_in_box(in_tri, root_r);
              inrange_r  <= 1'b1;
              lvl_r      <= '0;
              state_r    <= tri_in_box(in_tri, root_r) ? S_DESCEND : S_RD;
            end
          end
        end
        S_DESCEND: begin
          if (hit != 8'd0 && lvl_r < LVL_W'(TREE_LEVELS - 1)) begin
            box_r <= child[pick];
            idx_r <= {idx_r[IDX_W-4:0], pick};
            lvl_r <= lvl_r + 1'b1;
          end else begin
            addr_r  <= level_start(lvl_r) + idx_r[AW-1:0];
            state_r <= S_RD;
          end
        end
        S_RD: begin
          // Read data appears next cycle.
          state_r <= S_WR;
        end
        S_WR: begin
          state_r <= S_OUT;
          if (kind_r == KIND_READ) begin
            res_inside_r <= 1'b0;
            res_node_r   <= rnode_r;
            res_lvl_r    <= inrange_r ? lvl_r : '0;
            res_total_r  <= inrange_r ? 24'(ram_rdata) : '0;
          end else if (hit_root_r) begin
            res_inside_r <= 1'b1;
            res_node_r   <= 16'(addr_r);
            res_lvl_r    <= lvl_r;
            res_total_r  <= 24'(new_cnt);
          end else begin
            res_inside_r <= 1'b0;
            res_node_r   <= '0;
            res_lvl_r    <= '0;
            res_total_r  <= '0;
          end
        end
        S_OUT: begin
          if (out_acc) state_r <= S_IDLE;
        end
        default: state_r <= S_CLEAR;
      endcase
    end
  end

  assign out_inside_root = res_inside_r;
  assign out_node_number = res_node_r;
  assign out_node_level  = res_lvl_r;
  assign out_node_total  = res_total_r;

  // Checks.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input accepted while a result is pending");
  a_read_not_inside: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && kind_r == KIND_READ) |-> !out_inside_root)
    else $error("read result flagged as counted");
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_node_level < LVL_W'(TREE_LEVELS)))
    else $error("level out of range");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result dropped");

endmodule

[tb/sv/tb_octree_face_binning.sv]
// Self-checking testbench for octree_face_binning: directed table, then random
// bin and read items over several root boxes, checked against a local predictor.
// Depends on ofb_pkg and the octree_face_binning RTL.
module tb_octree_face_binning;
  import ofb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LEVELS = 6;
  localparam int NODES = 37449;
  localparam logic [23:0] COUNT_TOP = 24'hFF_FFFF;
  localparam logic [2:0] IDX_SPARE0 = 3'd6;
  localparam logic [2:0] IDX_SPARE1 = 3'd7;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int PER_PHASE = 180;

  typedef logic [31:0] coords_t [9];

  typedef struct packed {
    logic        counted;
    logic [15:0] num;
    logic [2:0]  lvl;
    logic [23:0] tot;
  } bin_result_t;

  typedef struct {
    logic        kind;
    coords_t     c;
    logic [15:0] rn;
    bit          typed;
    bin_result_t res;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_kind = 1'b0;
  logic [31:0] in_ax = '0, in_ay = '0, in_az = '0;
  logic [31:0] in_bx = '0, in_by = '0, in_bz = '0;
  logic [31:0] in_cx = '0, in_cy = '0, in_cz = '0;
  logic [15:0] in_read_node = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_inside_root;
  logic [15:0] out_node_number;
  logic [2:0]  out_node_level;
  logic [23:0] out_node_total;

  // Local copy of the box registers (signed Q16.16) and the counter store.
  logic [31:0] box_reg [6];
  logic [23:0] node_tally [NODES];
  bin_result_t pending_results [$];
  int  errors = 0;
  int  accepted = 0;
  int  cycles = 0;
  bit  calm = 1'b0;
  bit  held_off = 1'b0;

  octree_face_binning dut (.*);

  // Clock: 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic int unsigned level_first(int lvl);
    return ((1 << (3 * lvl)) - 1) / 7;
  endfunction

  function automatic bit all_within(logic [31:0] p [9], logic [31:0] lo [3],
                                    logic [31:0] hi [3]);
    for (int i = 0; i < 9; i++)
      if (p[i] < lo[i % 3] || p[i] > hi[i % 3]) return 1'b0;
    return 1'b1;
  endfunction

  // Predicts one result and updates the local counter store.
  function automatic bin_result_t bin_predict(logic kind, coords_t v, logic [15:0] rn);
    bin_result_t r;
    logic [31:0] p [9];
    logic [31:0] lo [3], hi [3], mid [3], clo [3], chi [3];
    logic [32:0] sum;
    int lvl;
    int unsigned idx, node;
    bit found, hx, hy, hz;
    r = '0;
    if (kind == KIND_READ) begin
      r.num = rn;
      if (rn < NODES) begin
        lvl = 0;
        while (lvl + 1 < LEVELS && rn >= level_first(lvl + 1)) lvl++;
        r.lvl = lvl[2:0];
        r.tot = node_tally[rn];
      end
      return r;
    end
    for (int i = 0; i < 9; i++) p[i] = v[i] ^ SIGN_BIAS;
    for (int a = 0; a < 3; a++) begin
      lo[a] = box_reg[2*a] ^ SIGN_BIAS;
      hi[a] = box_reg[2*a+1] ^ SIGN_BIAS;
    end
    if (!all_within(p, lo, hi)) return r;
    lvl = 0;
    idx = 0;
    while (lvl + 1 < LEVELS) begin
      found = 1'b0;
      for (int a = 0; a < 3; a++) begin
        sum = {1'b0, lo[a]} + {1'b0, hi[a]};
        mid[a] = sum[32:1];
      end
      // Octant order: x lo/lo/hi/hi and y lo/hi/hi/lo, z low half first.
      for (int i = 0; i < 8 && !found; i++) begin
        hx = (i & 3) >= 2;
        hy = (i & 3) == 1 || (i & 3) == 2;
        hz = i >= 4;
        clo[0] = hx ? mid[0] : lo[0]; chi[0] = hx ? hi[0] : mid[0];
        clo[1] = hy ? mid[1] : lo[1]; chi[1] = hy ? hi[1] : mid[1];
        clo[2] = hz ? mid[2] : lo[2]; chi[2] = hz ? hi[2] : mid[2];
        if (all_within(p, clo, chi)) begin
          found = 1'b1;
          idx = idx * 8 + i;
          lo = clo;
          hi = chi;
        end
      end
      if (!found) break;
      lvl++;
    end
    node = level_first(lvl) + idx;
    if (node_tally[node] != COUNT_TOP) node_tally[node] = node_tally[node] + 1'b1;
    r.counted = 1'b1;
    r.num = node[15:0];
    r.lvl = lvl[2:0];
    r.tot = node_tally[node];
    return r;
  endfunction

  // Gap length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offers one item and waits for its transfer.
  task automatic send_item(logic kind, coords_t c, logic [15:0] rn, bit typed,
                           bin_result_t res);
    int g;
    bin_result_t pred;
    in_valid <= 1'b1;
    in_kind <= kind;
    in_ax <= c[0]; in_ay <= c[1]; in_az <= c[2];
    in_bx <= c[3]; in_by <= c[4]; in_bz <= c[5];
    in_cx <= c[6]; in_cy <= c[7]; in_cz <= c[8];
    in_read_node <= rn;
    do @(posedge clk); while (in_stall);
    pred = bin_predict(kind, c, rn);
    pending_results.push_back(typed ? res : pred);
    accepted++;
    g = pick_gap();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    if (idx < 6) box_reg[idx] = data;
  endtask

  // Waits until the block is idle, then loads a new root box.
  task automatic load_box(logic [31:0] x0, logic [31:0] x1, logic [31:0] y0,
                          logic [31:0] y1, logic [31:0] z0, logic [31:0] z1);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    write_reg(REG_X_MIN, x0);
    write_reg(REG_X_MAX, x1);
    write_reg(REG_Y_MIN, y0);
    write_reg(REG_Y_MAX, y1);
    write_reg(REG_Z_MIN, z0);
    write_reg(REG_Z_MAX, z1);
    // Writes to unused indexes must be ignored.
    write_reg(IDX_SPARE0, $urandom);
    write_reg(IDX_SPARE1, $urandom);
    cfg_we <= 1'b0;
  endtask

  // One random item: mostly compact triangles inside the box, some reads and noise.
  task automatic random_item();
    coords_t c;
    logic [31:0] lo, hi;
    logic [32:0] w, off, spread, o;
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      send_item(KIND_READ, c, ($urandom_range(0, 9) == 0) ? 16'($urandom) :
                16'($urandom_range(0, NODES - 1)), 1'b0, '0);
      return;
    end
    for (int i = 0; i < 9; i++) c[i] = $urandom;
    if (r >= 25) begin
      for (int a = 0; a < 3; a++) begin
        lo = box_reg[2*a] ^ SIGN_BIAS;
        hi = box_reg[2*a+1] ^ SIGN_BIAS;
        if (lo > hi) continue;
        w = {1'b0, hi} - {1'b0, lo};
        off = {1'b0, $urandom} % (w + 1);
        spread = w >> $urandom_range(0, 24);
        for (int p = 0; p < 3; p++) begin
          o = off + ({1'b0, $urandom} % (spread + 1));
          if (o > w) o = w;
          c[p*3+a] = (lo + o[31:0]) ^ SIGN_BIAS;
        end
      end
    end
    send_item(KIND_BIN, c, 16'($urandom), 1'b0, '0);
  endtask

  // Directed rows on the reset box [0, 65536] on every axis.
  stim_row_t directed [] = '{
    '{KIND_READ, '{default: 0}, 16'd0, 1'b1, '{1'b0, 16'd0, 3'd0, 24'd0}},
    '{KIND_READ, '{default: 0}, 16'd37448, 1'b1, '{1'b0, 16'd37448, 3'd5, 24'd0}},
    '{KIND_READ, '{default: 0}, 16'd37449, 1'b1, '{1'b0, 16'd37449, 3'd0, 24'd0}},
    '{KIND_READ, '{default: 0}, 16'hFFFF, 1'b1, '{1'b0, 16'hFFFF, 3'd0, 24'd0}},
    '{KIND_BIN, '{default: 0}, 16'd0, 1'b0, '0},
    '{KIND_BIN, '{default: 32'd65536}, 16'd0, 1'b0, '0},
    '{KIND_BIN, '{default: 32'd32768}, 16'd0, 1'b0, '0},
    '{KIND_BIN, '{32'd0, 32'd0, 32'd0, 32'd65536, 32'd65536, 32'd65536,
                 32'd5, 32'd5, 32'd5}, 16'd0, 1'b0, '0},
    '{KIND_BIN, '{32'd100, 32'd100, 32'd100, 32'd101, 32'd102, 32'd103,
                 32'd104, 32'd100, 32'd101}, 16'd0, 1'b0, '0},
    '{KIND_BIN, '{32'd100, 32'd100, 32'd100, 32'd101, 32'd102, 32'd103,
                 32'd104, 32'd100, 32'd101}, 16'd0, 1'b0, '0},
    '{KIND_BIN, '{32'hFFFF_FFFF, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1,
                 32'd1, 32'd1, 32'd1}, 16'd0, 1'b1, '0},
    '{KIND_BIN, '{32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1,
                 32'd1, 32'd1, 32'd65537}, 16'd0, 1'b1, '0},
    '{KIND_BIN, '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0, 32'd0, 32'd0}, 16'd0, 1'b1, '0},
    '{KIND_BIN, '{32'd32768, 32'd40000, 32'd1000, 32'd60000, 32'd32768, 32'd2000,
                 32'd50000, 32'd50000, 32'd32768}, 16'd0, 1'b0, '0},
    '{KIND_READ, '{default: 0}, 16'd0, 1'b0, '0},
    '{KIND_READ, '{default: 0}, 16'd1, 1'b0, '0}
  };

  // Result checking against the oldest expectation.
  always @(posedge clk) begin
    bin_result_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing expected");
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (out_inside_root !== e.counted) begin
          $error("inside_root: expected %0d, got %0d", e.counted, out_inside_root);
          errors++;
        end
        if (out_node_number !== e.num) begin
          $error("node_number: expected %0d, got %0d", e.num, out_node_number);
          errors++;
        end
        if (out_node_level !== e.lvl) begin
          $error("node_level: expected %0d, got %0d", e.lvl, out_node_level);
          errors++;
        end
        if (out_node_total !== e.tot) begin
          $error("node_total: expected %0d, got %0d", e.tot, out_node_total);
          errors++;
        end
      end
    end
  end

  // Receiver stalls, with one long hold-off once the run is under way.
  initial begin
    int g;
    forever begin
      if (!held_off && accepted >= 300) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        held_off = 1'b1;
      end
      g = pick_gap();
      if (g > 0) begin
        out_stall <= 1'b1;
        repeat (g) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
    end
  end

  // Reset, directed table, then random phases over several boxes.
  initial begin
    box_reg = '{32'd0, 32'd65536, 32'd0, 32'd65536, 32'd0, 32'd65536};
    foreach (node_tally[i]) node_tally[i] = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i])
      send_item(directed[i].kind, directed[i].c, directed[i].rn, directed[i].typed,
                directed[i].res);
    repeat (PER_PHASE) random_item();

    // Widest possible box.
    load_box(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
             32'h8000_0000, 32'h7FFF_FFFF);
    calm = 1'b1;
    repeat (PER_PHASE) random_item();
    calm = 1'b0;

    // Tiny box: midpoints collide with the bounds.
    load_box(32'd5, 32'd12, 32'hFFFF_FFFD, 32'd3, 32'd7, 32'd7);
    repeat (PER_PHASE) random_item();

    // Inverted x bounds: nothing may be counted.
    load_box(32'd65536, 32'd0, 32'd0, 32'd65536, 32'd0, 32'd65536);
    repeat (PER_PHASE / 2) random_item();

    // Random boxes, ordered on each axis.
    for (int k = 0; k < 2; k++) begin
      logic [31:0] b [6];
      for (int a = 0; a < 3; a++) begin
        b[2*a] = $urandom;
        b[2*a+1] = $urandom;
        if ($signed(b[2*a]) > $signed(b[2*a+1])) begin
          b[2*a] ^= b[2*a+1]; b[2*a+1] ^= b[2*a]; b[2*a] ^= b[2*a+1];
        end
      end
      load_box(b[0], b[1], b[2], b[3], b[4], b[5]);
      repeat (PER_PHASE) random_item();
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

[octree_face_binning.f]
rtl/ofb_pkg.sv
rtl/ofb_ram.sv
rtl/ofb_lane.sv
rtl/octree_face_binning.sv
tb/sv/tb_octree_face_binning.sv
